/* sv/gregorian_to_jalali_date_defines.svh */
// Assertion macros for the Gregorian to Jalali date converter.
// Used by gregorian_to_jalali_date.sv; expects clk and arst_n in scope.
`ifndef GREGORIAN_TO_JALALI_DATE_DEFINES_SVH
`define GREGORIAN_TO_JALALI_DATE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define G2J_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside of reset.
`define G2J_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/g2j_pkg.sv */
// Package for the Gregorian to Jalali date converter: payload types,
// calendar constants and the two month tables. No dependencies.
`timescale 1ns / 1ps

package g2j_pkg;

	localparam int unsigned DATA_W = 24;

	// Input item as packed in tdata, first field in the highest bits.
	typedef struct packed {
		logic       pad;
		logic [4:0] day;
		logic [3:0] month;
		logic [13:0] year;
	} greg_date_t;

	// Result item as packed in tdata.
	typedef struct packed {
		logic       pad;
		logic [4:0] day;
		logic [3:0] month;
		logic [13:0] year;
	} jal_date_t;

	localparam logic [13:0] YEAR_BASE   = 14'd1600;
	localparam logic [13:0] YEAR_MIN    = 14'd1601;
	localparam logic [22:0] EPOCH_OFS   = 23'd79;
	localparam logic [14:0] CYCLE_DAYS  = 15'd12053;
	localparam logic [11:0] GROUP_DAYS  = 12'd1461;
	localparam logic [13:0] JAL_YEAR0   = 14'd979;
	localparam logic [13:0] CYCLE_YEARS = 14'd33;
	localparam logic [10:0] YEAR_DAYS   = 11'd365;
	localparam logic [10:0] LEAP_DAYS   = 11'd366;

	// Reciprocals for constant division; cycle and group ones underestimate
	// by at most one over the operand range, fixed by one compare-subtract.
	localparam logic [12:0] RECIP_100   = 13'd5243;   // exact floor, shift 19
	localparam logic [10:0] RECIP_CYCLE = 11'd1391;   // shift 24
	localparam logic [3:0]  RECIP_GROUP = 4'd11;      // shift 14

	// Days before the first of each Gregorian month in a common year.
	function automatic logic [8:0] greg_cum_days(input logic [3:0] mo);
		logic [8:0] r;
		unique case (mo)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd59;
			4'd3:    r = 9'd90;
			4'd4:    r = 9'd120;
			4'd5:    r = 9'd151;
			4'd6:    r = 9'd181;
			4'd7:    r = 9'd212;
			4'd8:    r = 9'd243;
			4'd9:    r = 9'd273;
			4'd10:   r = 9'd304;
			4'd11:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Day of the Jalali year on which each month starts, counted from 0.
	function automatic logic [8:0] jal_month_start(input logic [3:0] mo);
		logic [8:0] r;
		unique case (mo)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd62;
			4'd3:    r = 9'd93;
			4'd4:    r = 9'd124;
			4'd5:    r = 9'd155;
			4'd6:    r = 9'd186;
			4'd7:    r = 9'd216;
			4'd8:    r = 9'd246;
			4'd9:    r = 9'd276;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd336;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

/* sv/gregorian_to_jalali_date.sv */
// Gregorian to Jalali date converter, a twelve-stage pipeline.
// Depends on g2j_pkg and gregorian_to_jalali_date_defines.svh.
`timescale 1ns / 1ps
`include "gregorian_to_jalali_date_defines.svh"

// How to use this block:
// An input item is a Gregorian date on the s_axis channel, taken at a rising
// edge where s_axis_tvalid and s_axis_tready are both high. The matching
// Jalali date leaves on the m_axis channel, one result item per input item,
// in order. Years below 1601 are converted as 1601; a month of zero counts
// as January and one above twelve as December; the day is not checked
// against the month length and simply counts on from the first of the month.
// m_axis_tvalid rises when the item reaches the last stage, and the result item
// is taken at a rising edge where m_axis_tready is high.
// The pipeline takes one item per cycle while m_axis_tready does not hold it
// back; the work is split over twelve register stages, with the
// constant-reciprocal multipliers for the 33-year cycle and 4-year group
// each given a stage of its own and the century one sharing stage 2.
// Every stage has its own valid bit and advances when it is empty or when
// the stage after it advances, so a stall on m_axis_tready compresses any
// bubbles first and only then pushes back on s_axis_tready. Nothing is lost
// or repeated under stalls. Reset (arst_n low) empties every stage at once;
// the block has no configuration and no other state.
module gregorian_to_jalali_date
	import g2j_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// greg_year [13:0], greg_month [17:14], greg_day [22:18], zero [23]
	input  logic [DATA_W-1:0]   s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// jal_year [13:0], jal_month [17:14], jal_day [22:18], zero [23]
	output logic [DATA_W-1:0]   m_axis_tdata
);

	localparam int unsigned NSTAGE = 12;

	// Stage valid bits, reset to empty.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic [NSTAGE:1] vld;
	logic [NSTAGE:1] en;

	greg_date_t in_d;
	assign in_d = s_axis_tdata;

	// Stage 1: clamped year offset, month index and raw day.
	logic [13:0] yo_s1;
	logic [3:0]  mo_s1;
	logic [4:0]  day_s1;

	// Stage 2: the products and the small terms of the day count.
	logic [7:0]  qa_s2;          // floor(yo / 100)
	logic [13:0] yo_s2;
	logic [22:0] y365_s2;
	logic [12:0] c4_s2;
	logic [8:0]  cum_s2;         // month start plus day
	logic        leap4_s2;
	logic        late_s2;        // month past February

	// Stage 3: century terms resolved, main sum formed.
	logic [22:0] part_s3;
	logic [7:0]  c100_s3;
	logic [5:0]  c400_s3;
	logic        ladd_s3;

	// Stages 4 to 12.
	logic [22:0] dn_s4;
	logic [22:0] dn_s5;
	logic [8:0]  cq_s5;
	logic [14:0] r0_s6;
	logic [8:0]  cq_s6;
	logic [13:0] k1_s7;
	logic [8:0]  cyc_s7;
	logic [13:0] k1_s8;
	logic [8:0]  cyc_s8;
	logic [3:0]  gq_s8;
	logic [11:0] r1_s9;
	logic [8:0]  cyc_s9;
	logic [3:0]  gq_s9;
	logic [10:0] k2_s10;
	logic [8:0]  cyc_s10;
	logic [3:0]  g_s10;
	logic [13:0] jy_s11;
	logic [8:0]  k3_s11;
	jal_date_t   out_s12;

	// Combinational helpers.
	logic [26:0] qa_prod;
	logic [32:0] cq_prod;
	logic [17:0] gq_prod;
	logic        m100z;
	logic [7:0]  c100_c;
	logic [10:0] yk;
	logic [1:0]  yq;
	logic [3:0]  jm;
	logic [8:0]  jday;

	assign vld = {v_s12, v_s11, v_s10, v_s9, v_s8, v_s7, v_s6, v_s5, v_s4, v_s3, v_s2, v_s1};

	// A stage loads when it is empty or its item moves on.
	always_comb begin
		en[NSTAGE] = !vld[NSTAGE] || m_axis_tready;
		for (int i = NSTAGE - 1; i >= 1; i--) begin
			en[i] = !vld[i] || en[i+1];
		end
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = v_s12;
	assign m_axis_tdata  = out_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			if (en[1])  v_s1  <= s_axis_tvalid;
			if (en[2])  v_s2  <= v_s1;
			if (en[3])  v_s3  <= v_s2;
			if (en[4])  v_s4  <= v_s3;
			if (en[5])  v_s5  <= v_s4;
			if (en[6])  v_s6  <= v_s5;
			if (en[7])  v_s7  <= v_s6;
			if (en[8])  v_s8  <= v_s7;
			if (en[9])  v_s9  <= v_s8;
			if (en[10]) v_s10 <= v_s9;
			if (en[11]) v_s11 <= v_s10;
			if (en[12]) v_s12 <= v_s11;
		end
	end

	// The year divided by 100 comes from a reciprocal product; the same
	// quotient gives both the mod-100 test and the rounded-up century counts,
	// since ceil(y/400) equals ceil(ceil(y/100)/4).
	assign qa_prod = 27'(yo_s1) * 27'(RECIP_100);
	assign m100z   = (15'(qa_s2) * 15'd100) == 15'(yo_s2);
	assign c100_c  = qa_s2 + 8'(!m100z);

	// Quotient estimates for the 33-year cycle and the 4-year group.
	assign cq_prod = 33'(dn_s4) * 33'(RECIP_CYCLE);
	assign gq_prod = 18'(k1_s7) * 18'(RECIP_GROUP);

	// Position inside a 4-year group: the first year has 366 days.
	always_comb begin
		yq = 2'd0;
		yk = k2_s10;
		if (k2_s10 >= LEAP_DAYS) begin
			if (k2_s10 - 11'd1 >= 11'd3 * YEAR_DAYS) begin
				yq = 2'd3;
				yk = k2_s10 - 11'd1 - 11'd3 * YEAR_DAYS;
			end else if (k2_s10 - 11'd1 >= 11'd2 * YEAR_DAYS) begin
				yq = 2'd2;
				yk = k2_s10 - 11'd1 - 11'd2 * YEAR_DAYS;
			end else begin
				yq = 2'd1;
				yk = k2_s10 - 11'd1 - YEAR_DAYS;
			end
		end
	end

	// Month: the last month whose start is not past the day of the year.
	always_comb begin
		jm = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (k3_s11 >= jal_month_start(4'(i))) begin
				jm = 4'(i);
			end
		end
		jday = k3_s11 - jal_month_start(jm) + 9'd1;
	end

	// Payload registers, no reset.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			yo_s1  <= (in_d.year < YEAR_MIN) ? (YEAR_MIN - YEAR_BASE) : (in_d.year - YEAR_BASE);
			if (in_d.month == 4'd0) begin
				mo_s1 <= 4'd0;
			end else if (in_d.month > 4'd12) begin
				mo_s1 <= 4'd11;
			end else begin
				mo_s1 <= in_d.month - 4'd1;
			end
			day_s1 <= in_d.day;
		end
		if (en[2]) begin
			qa_s2    <= qa_prod[26:19];
			yo_s2    <= yo_s1;
			y365_s2  <= 23'(yo_s1) * 23'(YEAR_DAYS);
			c4_s2    <= 13'((15'(yo_s1) + 15'd3) >> 2);
			cum_s2   <= greg_cum_days(mo_s1) + 9'(day_s1);
			leap4_s2 <= (yo_s1[1:0] == 2'd0);
			late_s2  <= (mo_s1 > 4'd1);
		end
		if (en[3]) begin
			part_s3 <= y365_s2 + 23'(c4_s2) + 23'(cum_s2);
			c100_s3 <= c100_c;
			c400_s3 <= 6'((9'(c100_c) + 9'd3) >> 2);
			ladd_s3 <= late_s2 && leap4_s2 && (!m100z || (qa_s2[1:0] == 2'd0));
		end
		if (en[4]) begin
			// The day field counts from 1, hence one more than the epoch offset.
			dn_s4 <= part_s3 + 23'(c400_s3) + 23'(ladd_s3) - 23'(c100_s3)
				- (EPOCH_OFS + 23'd1);
		end
		if (en[5]) begin
			dn_s5 <= dn_s4;
			cq_s5 <= cq_prod[32:24];
		end
		if (en[6]) begin
			r0_s6 <= 15'(dn_s5 - 23'(cq_s5) * 23'(CYCLE_DAYS));
			cq_s6 <= cq_s5;
		end
		if (en[7]) begin
			if (r0_s6 >= CYCLE_DAYS) begin
				k1_s7  <= 14'(r0_s6 - CYCLE_DAYS);
				cyc_s7 <= cq_s6 + 9'd1;
			end else begin
				k1_s7  <= 14'(r0_s6);
				cyc_s7 <= cq_s6;
			end
		end
		if (en[8]) begin
			k1_s8  <= k1_s7;
			cyc_s8 <= cyc_s7;
			gq_s8  <= gq_prod[17:14];
		end
		if (en[9]) begin
			r1_s9  <= 12'(k1_s8 - 14'(gq_s8) * 14'(GROUP_DAYS));
			cyc_s9 <= cyc_s8;
			gq_s9  <= gq_s8;
		end
		if (en[10]) begin
			if (r1_s9 >= GROUP_DAYS) begin
				k2_s10 <= 11'(r1_s9 - GROUP_DAYS);
				g_s10  <= gq_s9 + 4'd1;
			end else begin
				k2_s10 <= 11'(r1_s9);
				g_s10  <= gq_s9;
			end
			cyc_s10 <= cyc_s9;
		end
		if (en[11]) begin
			jy_s11 <= JAL_YEAR0 + CYCLE_YEARS * 14'(cyc_s10) + 14'({g_s10, 2'b00})
				+ 14'(yq);
			k3_s11 <= 9'(yk);
		end
		if (en[12]) begin
			out_s12.pad   <= 1'b0;
			out_s12.year  <= jy_s11;
			out_s12.month <= jm + 4'd1;
			out_s12.day   <= 5'(jday);
		end
	end

	// A taken item always occupies the first stage on the next cycle.
	`G2J_ASSERT_NEXT(a_take_fills_s1, s_axis_tvalid && s_axis_tready, v_s1,
		"accepted item did not reach stage 1")
	// The 33-year remainder is reduced below CYCLE_DAYS after the correction step.
	`G2J_ASSERT_NOW(a_cycle_rem, v_s7, k1_s7 < 14'(CYCLE_DAYS),
		"33-year cycle remainder out of range")
	// Group remainder is reduced below one 4-year group.
	`G2J_ASSERT_NOW(a_group_rem, v_s10, k2_s10 < 11'(GROUP_DAYS),
		"4-year group remainder out of range")
	// A delivered month and day are never zero and the month never above twelve.
	`G2J_ASSERT_NOW(a_out_range, m_axis_tvalid,
		(out_s12.month != 4'd0) && (out_s12.month <= 4'd12) && (out_s12.day != 5'd0),
		"result month or day out of range")

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for gregorian_to_jalali_date: directed dates, then random dates.
// The stream ports are driven with random gaps on both sides and checked against a predictor.
// Depends on g2j_pkg and the gregorian_to_jalali_date RTL.
`timescale 1ns / 1ps

module tb_top;
	import g2j_pkg::*;

	localparam int N_DIRECTED  = 20;
	localparam int N_RANDOM    = 1600;
	localparam int PIPE_DEPTH  = 12;
	localparam int LONG_HOLD   = 80;
	localparam int IDLE_LIMIT  = 1000;

	// Days before the first of each Gregorian month in a common year.
	localparam int unsigned MONTH_OFS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
		304, 334};

	typedef struct packed {
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		logic        known;
		logic [13:0] jy;
		logic [3:0]  jm;
		logic [4:0]  jd;
	} date_row_t;

	// Rows marked known carry a result that can be worked out by hand; all other
	// rows are checked against the predictor.
	date_row_t directed_dates [N_DIRECTED] = '{
		'{14'd1601,  4'd1,  5'd1,  1'b1, 14'd979, 4'd10, 5'd12},
		'{14'd0,     4'd1,  5'd1,  1'b1, 14'd979, 4'd10, 5'd12},  // year saturates
		'{14'd1600,  4'd0,  5'd1,  1'b1, 14'd979, 4'd10, 5'd12},  // month zero too
		'{14'd1601,  4'd1,  5'd0,  1'b1, 14'd979, 4'd10, 5'd11},  // day zero
		'{14'd16383, 4'd15, 5'd31, 1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd9999,  4'd12, 5'd31, 1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd1601,  4'd13, 5'd5,  1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd2000,  4'd2,  5'd29, 1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd2000,  4'd3,  5'd1,  1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd2100,  4'd3,  5'd1,  1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd2400,  4'd3,  5'd1,  1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd2024,  4'd3,  5'd20, 1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd2024,  4'd3,  5'd19, 1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd1601,  4'd12, 5'd31, 1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd1601,  4'd2,  5'd31, 1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd8191,  4'd7,  5'd16, 1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd10922, 4'd10, 5'd10, 1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd5461,  4'd5,  5'd21, 1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd2023,  4'd3,  5'd21, 1'b0, 14'd0,   4'd0,  5'd0},
		'{14'd1700,  4'd12, 5'd31, 1'b0, 14'd0,   4'd0,  5'd0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;

	jal_date_t jal_q [$];
	int        err_count = 0;
	int        idle_cycles = 0;
	bit        calm = 1'b0;      // neither side idles
	bit        rush = 1'b0;      // sender offers back to back
	bit        hold_req = 1'b0;  // asks the receiver for one long hold-off

	gregorian_to_jalali_date uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	function automatic jal_date_t jalali_of(greg_date_t g);
		int unsigned yr, mo, yo, cnt, k, cyc, jy, jm;
		bit          leap;
		jal_date_t   j;
		yr = g.year;
		mo = g.month;
		if (yr < 1601) yr = 1601;
		if (mo < 1) mo = 1;
		if (mo > 12) mo = 12;
		yo = yr - 1600;
		cnt = 365 * yo + (yo + 3) / 4 - (yo + 99) / 100 + (yo + 399) / 400 + MONTH_OFS[mo - 1];
		leap = ((yo % 4 == 0) && (yo % 100 != 0)) || (yo % 400 == 0);
		if (mo > 2 && leap) cnt++;
		// The count is at least 366 here, so removing the epoch offset cannot wrap.
		k = cnt + g.day - 1 - 79;
		cyc = k / 12053;
		k = k % 12053;
		jy = 979 + 33 * cyc + 4 * (k / 1461);
		k = k % 1461;
		// First year of each four-year group is the long one.
		if (k >= 366) begin
			jy += (k - 1) / 365;
			k = (k - 1) % 365;
		end
		jm = 0;
		while (jm < 11 && k >= ((jm < 6) ? 31 : 30)) begin
			k -= (jm < 6) ? 31 : 30;
			jm++;
		end
		j.pad = 1'b0;
		j.year = jy[13:0];
		j.month = 4'(jm + 1);
		j.day = 5'(k + 1);
		return j;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// Called at a falling edge; returns at the falling edge after the handshake.
	task automatic send_date(greg_date_t g, jal_date_t want);
		int gap;
		gap = (calm || rush) ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= g;
		do @(posedge clk); while (!s_axis_tready);
		jal_q.push_back(want);
		@(negedge clk);
	endtask

	// Receiver: short stalls mostly, some long ones, one requested long hold-off.
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				r = $urandom_range(0, 99);
				if (!calm) begin
					if (r < 20) stall_left = $urandom_range(1, 3);
					else if (r < 23) stall_left = $urandom_range(10, 40);
				end
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		jal_date_t got;
		jal_date_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (jal_q.size() == 0) begin
				report_mismatch("result with nothing pending, year", got.year, 0);
			end else begin
				want = jal_q.pop_front();
				if (got.year !== want.year) report_mismatch("jal_year", got.year, want.year);
				if (got.month !== want.month) report_mismatch("jal_month", got.month, want.month);
				if (got.day !== want.day) report_mismatch("jal_day", got.day, want.day);
			end
		end
	end

	// Watchdog on cycles with no handshake on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		greg_date_t g;
		jal_date_t  want;
		date_row_t  row;
		int         r;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_dates[i]) begin
			row = directed_dates[i];
			g.pad = 1'b0;
			g.year = row.y;
			g.month = row.m;
			g.day = row.d;
			want = row.known ? jal_date_t'({1'b0, row.jd, row.jm, row.jy}) : jalali_of(g);
			send_date(g, want);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 400) begin
				// Sender waits for the pipeline to drain completely.
				s_axis_tvalid <= 1'b0;
				while (jal_q.size() != 0) @(negedge clk);
				@(negedge clk);
			end
			if (i == 800) begin
				// Receiver holds off while items keep coming, so the pipeline fills.
				hold_req = 1'b1;
				rush = 1'b1;
			end
			if (i == 860) rush = 1'b0;
			calm = (i >= 1100 && i < 1250);

			g.pad = 1'b0;
			r = $urandom_range(0, 99);
			if (r < 75) begin
				g.year = 14'($urandom_range(1601, 9999));
				g.month = 4'($urandom_range(1, 12));
				g.day = 5'($urandom_range(1, 31));
			end else begin
				g.year = 14'($urandom_range(0, 16383));
				g.month = 4'($urandom_range(0, 15));
				g.day = 5'($urandom_range(0, 31));
			end
			send_date(g, jalali_of(g));
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b0;

		while (jal_q.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		if (err_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/g2j_pkg.sv
sv/gregorian_to_jalali_date.sv
dv/tb_top.sv
